// ===== design/vsse_pkg.sv =====
// ----------------------------------------------------------------------------
// vsse_pkg
// Types, codes and constants of the video scope statistics engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package vsse_pkg;

	localparam int LEVELS  = 256;
	localparam int LANES   = 6;
	localparam int COUNT_W = 24;
	localparam int NORM_W  = 32;
	localparam int HNORM_W = 31;
	localparam int DEN_W   = 25;

	localparam logic [COUNT_W-1:0] COUNT_MAX    = '1;
	localparam logic [NORM_W-1:0]  HIST_SCALE   = 32'd2080374784;
	localparam logic [NORM_W-1:0]  PARADE_SCALE = 32'h8000_0000;

	localparam logic [2:0] OP_CLEAR  = 3'd0;
	localparam logic [2:0] OP_PIXEL  = 3'd1;
	localparam logic [2:0] OP_CHROMA = 3'd2;
	localparam logic [2:0] OP_FINISH = 3'd3;
	localparam logic [2:0] OP_READ   = 3'd4;

	localparam logic [3:0] SEL_HIST_LAST   = 4'd5;
	localparam logic [3:0] SEL_PARADE_BASE = 4'd6;
	localparam logic [3:0] SEL_PARADE_LAST = 4'd11;
	localparam logic [3:0] SEL_SCOPE       = 4'd12;

	localparam logic CFG_WIDTH  = 1'b0;
	localparam logic CFG_HEIGHT = 1'b1;

	typedef logic [COUNT_W-1:0] count_t;
	typedef count_t [LANES-1:0] row_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [11:0] column;
		logic [7:0]  luma;
		logic [7:0]  red;
		logic [7:0]  green;
		logic [7:0]  blue;
		logic [7:0]  cb_sample;
		logic [7:0]  cr_sample;
		logic [3:0]  store_select;
		logic [15:0] bin_index;
	} item_t;

	typedef struct packed {
		logic [23:0] bin_value;
		logic        status;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_BKT_DIV,
		ST_BUMP_RD,
		ST_BUMP_WR,
		ST_MAX_RD,
		ST_MAX_ACC,
		ST_NORM_LOAD,
		ST_NORM_DIV,
		ST_READ_MEM,
		ST_READ_MUL,
		ST_READ_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== design/vsse_ifs.sv =====
// ----------------------------------------------------------------------------
// vsse item and result channels
// Valid/ready channels carrying one item or one result per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface vsse_item_if import vsse_pkg::*; ();
	logic  valid;
	logic  ready;
	item_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface vsse_result_if import vsse_pkg::*; ();
	logic    valid;
	logic    ready;
	result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/video_scope_statistics_engine_core.sv =====
// ----------------------------------------------------------------------------
// video_scope_statistics_engine_core
// Histogram, waveform parade and vectorscope counters with normalised read.
// ----------------------------------------------------------------------------
//  channel   dir  transaction
//  item      in   valid/ready, one operation (clear, pixel, chroma, finish, read)
//  result    out  valid/ready, one normalised bin for each read
//  cfg       in   cfg_write/cfg_index/cfg_data, frame width and height
//
//  Pixel: accept, then column bucket divide (skipped past the
//  line), then a counter read-modify-write per lane (4 for a pixel,
//  2 for chroma).
//  Read: memory, multiply, scale; waits while the result is held.
//  Finish: histogram sweep plus 3 normaliser divides.
//  Reset and clear run a pass over 65536 addresses zeroing all
//  memories; no item is taken meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module video_scope_statistics_engine_core import vsse_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	vsse_item_if.sink        item,
	vsse_result_if.source    result,
	input  wire logic        cfg_write,
	input  wire logic        cfg_index,
	input  wire logic [12:0] cfg_data
);

	state_t state_q, state_d;

	item_t              item_q;
	logic [1:0]         step_q;
	logic [15:0]        cnt_q;
	logic [7:0]         bucket_q;
	logic [1:0]         dsel_q;
	logic [12:0]        width_q;
	logic [11:0]        height_q;
	count_t             max_q [2];
	logic [HNORM_W-1:0] hnorm_q [2];
	logic [NORM_W-1:0]  pnorm_q;

	logic [DEN_W-1:0]   div_rem_q;
	logic [NORM_W-1:0]  div_dvd_q;
	logic [DEN_W-1:0]   div_den_q;
	logic [4:0]         div_cnt_q;

	logic [55:0]        prod_q;
	logic               rd_hist_q;
	logic               rd_bad_q;
	result_t            res_q;
	logic               res_valid_q;

	row_t               hist_mem [LEVELS];
	row_t               par_mem [LEVELS*LEVELS];
	count_t             scp_mem [LEVELS*LEVELS];
	row_t               hist_rd, par_rd, hist_wd, par_wd;
	count_t             scp_rd, scp_wd;
	logic [7:0]         hist_addr;
	logic [15:0]        par_addr, scp_addr;
	logic               hist_we, par_we, scp_we;

	logic               is_full;
	logic [7:0]         lvl;
	logic [2:0]         hlane, plane;
	logic [2:0]         amt;
	logic [DEN_W:0]     trial;
	logic               div_ge;
	logic [DEN_W-1:0]   rem_next;
	logic [NORM_W-1:0]  dvd_next;
	logic [DEN_W-1:0]   area;
	logic [DEN_W-1:0]   norm_den;
	count_t             m0, m1;
	count_t             rd_count;
	logic [NORM_W-1:0]  rd_norm;
	logic [23:0]        out_val;

	function automatic count_t sat_add(count_t c, logic [2:0] a);
		logic [COUNT_W:0] s;
		s = {1'b0, c} + {{(COUNT_W-2){1'b0}}, a};
		return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
	endfunction

	function automatic count_t max3(count_t a, count_t b, count_t c, count_t d);
		count_t m;
		m = a;
		if (b > m) m = b;
		if (c > m) m = c;
		if (d > m) m = d;
		return m;
	endfunction

	assign is_full = (item_q.operation == OP_PIXEL);
	assign amt     = is_full ? 3'd1 : 3'd4;
	assign area    = {12'd0, width_q} * {13'd0, height_q};

	always_comb begin
		lvl   = item_q.luma;
		hlane = 3'd3;
		plane = 3'd0;
		if (is_full) begin
			case (step_q)
				2'd0: begin lvl = item_q.red;   hlane = 3'd0; plane = 3'd3; end
				2'd1: begin lvl = item_q.green; hlane = 3'd1; plane = 3'd4; end
				2'd2: begin lvl = item_q.blue;  hlane = 3'd2; plane = 3'd5; end
				default: begin lvl = item_q.luma; hlane = 3'd3; plane = 3'd0; end
			endcase
		end else if (step_q == 2'd0) begin
			lvl = item_q.cb_sample; hlane = 3'd4; plane = 3'd1;
		end else begin
			lvl = item_q.cr_sample; hlane = 3'd5; plane = 3'd2;
		end
	end

	assign trial    = {div_rem_q, div_dvd_q[NORM_W-1]};
	assign div_ge   = trial >= {1'b0, div_den_q};
	assign rem_next = div_ge ? DEN_W'(trial - {1'b0, div_den_q}) : trial[DEN_W-1:0];
	assign dvd_next = {div_dvd_q[NORM_W-2:0], div_ge};

	always_comb begin
		case (dsel_q)
			2'd0:    norm_den = {1'b0, max_q[0]};
			2'd1:    norm_den = {1'b0, max_q[1]};
			default: norm_den = area;
		endcase
	end

	assign m0 = max3(max_q[0], hist_rd[0], hist_rd[1], hist_rd[2]);
	assign m1 = max3(max_q[1], hist_rd[3], hist_rd[4], hist_rd[5]);

	always_comb begin
		rd_count = scp_rd;
		rd_norm  = {1'b0, pnorm_q[NORM_W-1:1]};
		if (item_q.store_select inside {[4'd0:SEL_HIST_LAST]}) begin
			rd_count = hist_rd[item_q.store_select[2:0]];
			rd_norm  = {1'b0, hnorm_q[item_q.store_select >= 4'd3]};
		end else if (item_q.store_select inside {[SEL_PARADE_BASE:SEL_PARADE_LAST]}) begin
			rd_count = par_rd[3'(item_q.store_select - SEL_PARADE_BASE)];
			rd_norm  = pnorm_q;
		end
	end

	always_comb begin
		if (rd_bad_q) out_val = '0;
		else if (rd_hist_q) out_val = (|prod_q[55:48]) ? COUNT_MAX : prod_q[47:24];
		else out_val = (|prod_q[55:32]) ? COUNT_MAX : prod_q[31:8];
	end

	always_comb begin
		state_d    = state_q;
		item.ready = 1'b0;
		hist_addr  = lvl;
		par_addr   = {lvl, bucket_q};
		scp_addr   = {item_q.cr_sample, item_q.cb_sample};
		hist_we    = 1'b0;
		par_we     = 1'b0;
		scp_we     = 1'b0;
		hist_wd    = hist_rd;
		par_wd     = par_rd;
		scp_wd     = sat_add(scp_rd, 3'd1);
		hist_wd[hlane] = sat_add(hist_rd[hlane], amt);
		par_wd[plane]  = sat_add(par_rd[plane], amt);
		case (state_q)
			ST_IDLE: begin
				item.ready = 1'b1;
				if (item.valid) begin
					case (item.data.operation)
						OP_CLEAR:  state_d = ST_CLEAR;
						OP_PIXEL:  state_d = ({1'b0, item.data.column} >= width_q) ?
							ST_BUMP_RD : ST_BKT_DIV;
						OP_CHROMA: state_d = ({item.data.column, 1'b0} >= width_q) ?
							ST_BUMP_RD : ST_BKT_DIV;
						OP_FINISH: state_d = ST_MAX_RD;
						OP_READ:   state_d = ST_READ_MEM;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_CLEAR: begin
				hist_addr = cnt_q[7:0];
				par_addr  = cnt_q;
				scp_addr  = cnt_q;
				hist_we   = (cnt_q[15:8] == 8'd0);
				par_we    = 1'b1;
				scp_we    = 1'b1;
				hist_wd   = '0;
				par_wd    = '0;
				scp_wd    = '0;
				if (cnt_q == 16'hFFFF) state_d = ST_IDLE;
			end
			ST_BKT_DIV: begin
				if (div_cnt_q == 5'd7) state_d = ST_BUMP_RD;
			end
			ST_BUMP_RD: state_d = ST_BUMP_WR;
			ST_BUMP_WR: begin
				hist_we = 1'b1;
				par_we  = 1'b1;
				scp_we  = !is_full && (step_q == 2'd0);
				if ((is_full && step_q == 2'd3) || (!is_full && step_q == 2'd1))
					state_d = ST_IDLE;
				else
					state_d = ST_BUMP_RD;
			end
			ST_MAX_RD: begin
				hist_addr = cnt_q[7:0];
				state_d   = ST_MAX_ACC;
			end
			ST_MAX_ACC: begin
				state_d = (cnt_q[7:0] == 8'hFF) ? ST_NORM_LOAD : ST_MAX_RD;
			end
			ST_NORM_LOAD: begin
				if (norm_den == '0) state_d = (dsel_q == 2'd2) ? ST_IDLE : ST_NORM_LOAD;
				else state_d = ST_NORM_DIV;
			end
			ST_NORM_DIV: begin
				if (div_cnt_q == 5'd31) state_d = (dsel_q == 2'd2) ? ST_IDLE : ST_NORM_LOAD;
			end
			ST_READ_MEM: begin
				hist_addr = item_q.bin_index[7:0];
				par_addr  = item_q.bin_index;
				scp_addr  = item_q.bin_index;
				state_d   = ST_READ_MUL;
			end
			ST_READ_MUL: state_d = ST_READ_OUT;
			ST_READ_OUT: begin
				if (!res_valid_q || result.ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_CLEAR;
		else state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (hist_we) hist_mem[hist_addr] <= hist_wd;
		hist_rd <= hist_mem[hist_addr];
	end

	always_ff @(posedge clk) begin
		if (par_we) par_mem[par_addr] <= par_wd;
		par_rd <= par_mem[par_addr];
	end

	always_ff @(posedge clk) begin
		if (scp_we) scp_mem[scp_addr] <= scp_wd;
		scp_rd <= scp_mem[scp_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= 13'd1920;
			height_q <= 12'd1080;
		end else if (cfg_write) begin
			if (cfg_index == CFG_WIDTH) width_q <= cfg_data;
			if (cfg_index == CFG_HEIGHT) height_q <= cfg_data[11:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_q      <= '0;
			bucket_q    <= '0;
			div_rem_q   <= '0;
			div_dvd_q   <= '0;
			div_den_q   <= '0;
			prod_q      <= '0;
			rd_hist_q   <= 1'b0;
			rd_bad_q    <= 1'b0;
			res_q       <= '0;
			cnt_q       <= '0;
			step_q      <= '0;
			dsel_q      <= '0;
			div_cnt_q   <= '0;
			hnorm_q[0]  <= '0;
			hnorm_q[1]  <= '0;
			pnorm_q     <= '0;
			max_q[0]    <= '0;
			max_q[1]    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (result.ready && state_q != ST_READ_OUT) res_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					cnt_q     <= '0;
					step_q    <= '0;
					dsel_q    <= '0;
					div_cnt_q <= '0;
					if (item.valid) begin
						item_q   <= item.data;
						bucket_q <= 8'hFF;
						div_dvd_q <= '0;
						div_den_q <= {12'd0, width_q};
						if (item.data.operation == OP_PIXEL)
							div_rem_q <= {13'd0, item.data.column};
						else
							div_rem_q <= {12'd0, item.data.column, 1'b0};
						if (item.data.operation == OP_CLEAR) begin
							hnorm_q[0] <= '0;
							hnorm_q[1] <= '0;
							pnorm_q    <= '0;
						end
						if (item.data.operation == OP_FINISH) begin
							max_q[0] <= '0;
							max_q[1] <= '0;
						end
					end
				end
				ST_CLEAR: cnt_q <= cnt_q + 16'd1;
				ST_BKT_DIV: begin
					div_rem_q <= rem_next;
					div_dvd_q <= dvd_next;
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd7) bucket_q <= dvd_next[7:0];
				end
				ST_BUMP_WR: step_q <= step_q + 2'd1;
				ST_MAX_ACC: begin
					max_q[0] <= m0;
					max_q[1] <= m1;
					cnt_q    <= cnt_q + 16'd1;
				end
				ST_NORM_LOAD: begin
					div_rem_q <= '0;
					div_den_q <= norm_den;
					div_dvd_q <= (dsel_q == 2'd2) ? PARADE_SCALE : HIST_SCALE;
					div_cnt_q <= '0;
					if (norm_den == '0) begin
						dsel_q <= dsel_q + 2'd1;
						case (dsel_q)
							2'd0:    hnorm_q[0] <= '0;
							2'd1:    hnorm_q[1] <= '0;
							default: pnorm_q <= '0;
						endcase
					end
				end
				ST_NORM_DIV: begin
					div_rem_q <= rem_next;
					div_dvd_q <= dvd_next;
					div_cnt_q <= div_cnt_q + 5'd1;
					if (div_cnt_q == 5'd31) begin
						dsel_q <= dsel_q + 2'd1;
						case (dsel_q)
							2'd0:    hnorm_q[0] <= dvd_next[HNORM_W-1:0];
							2'd1:    hnorm_q[1] <= dvd_next[HNORM_W-1:0];
							default: pnorm_q <= dvd_next;
						endcase
					end
				end
				ST_READ_MUL: begin
					prod_q    <= {32'd0, rd_count} * {24'd0, rd_norm};
					rd_hist_q <= (item_q.store_select <= SEL_HIST_LAST);
					rd_bad_q  <= ((item_q.store_select <= SEL_HIST_LAST) &&
						(item_q.bin_index[15:8] != 8'd0)) ||
						(item_q.store_select > SEL_SCOPE);
				end
				ST_READ_OUT: begin
					if (!res_valid_q || result.ready) begin
						res_q.bin_value <= out_val;
						res_q.status    <= rd_bad_q;
						res_valid_q     <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	a_div_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BKT_DIV || state_q == ST_NORM_DIV) |-> div_rem_q < div_den_q)
		else $error("divider remainder not below divisor");

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		(hist_we || par_we || scp_we) |-> (state_q == ST_BUMP_WR || state_q == ST_CLEAR))
		else $error("memory write outside update or clear");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_READ_OUT)
		else $error("result raised without a read");

	a_clear_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR && cnt_q == 16'hFFFF) |=> state_q == ST_IDLE)
		else $error("clear pass did not finish");

endmodule

`default_nettype wire

// ===== dv/video_scope_statistics_engine_core_test.sv =====
// ----------------------------------------------------------------------------
// video_scope_statistics_engine_core_test
// Drives clear, pixel, chroma, finish and read operations through the item
// channel, and frame sizes through the register port. A predictor inside
// the bench keeps its own counters and normalizers and queues the bin
// expected for each read. The result channel is checked field by field, and
// both channels stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module video_scope_statistics_engine_core_test;
	import vsse_pkg::*;

	localparam logic [2:0] OP_UNKNOWN_LO = 3'd5;
	localparam logic [2:0] OP_UNKNOWN_HI = 3'd7;
	localparam logic [3:0] SEL_HIST_R = 4'd0;
	localparam logic [3:0] SEL_HIST_Y = 4'd3;
	localparam logic [3:0] SEL_HIST_U = 4'd4;
	localparam logic [3:0] SEL_PARADE_U = 4'd7;
	localparam logic [3:0] SEL_PARADE_G = 4'd10;
	localparam int ITEM_W = $bits(item_t);

	typedef struct {
		logic [3:0]  sel;
		logic [15:0] idx;
	} bin_ref_t;

	logic clk;
	logic arst_n;
	logic cfg_write;
	logic cfg_index;
	logic [12:0] cfg_data;

	vsse_item_if item ();
	vsse_result_if result ();

	video_scope_statistics_engine_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.source),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// predictor state
	logic [12:0] frame_w;
	logic [11:0] frame_h;
	logic [23:0] hist_cnt [0:1535];
	logic [23:0] parade_cnt [int];
	logic [23:0] scope_cnt [int];
	logic [23:0] space_max [0:1];
	logic [31:0] hist_norm [0:1];
	logic [31:0] parade_nrm;
	logic [31:0] scope_nrm;

	result_t  bins_due [$];
	item_t    pending [$];
	bin_ref_t touched [$];
	int       error_count;
	int       clears_left;
	bit       taken;
	int       gap_left;
	int       burst_left;
	int       rx_cycle;

	always #2 clk = ~clk;

	function automatic logic [23:0] bump(logic [23:0] v, int amount);
		logic [24:0] s;
		s = 25'(v) + 25'(amount);
		return (s > COUNT_MAX) ? COUNT_MAX : s[23:0];
	endfunction

	function automatic logic [7:0] bucket_of(logic [11:0] col, int scale);
		longint unsigned b;
		if (frame_w == 0)
			return 8'd255;
		b = (longint'(col) * scale) / frame_w;
		return (b > 255) ? 8'd255 : b[7:0];
	endfunction

	function automatic void note_bin(logic [3:0] sel, logic [15:0] idx);
		touched.push_back('{sel, idx});
		if (touched.size() > 40)
			void'(touched.pop_front());
	endfunction

	function automatic void clear_counts();
		foreach (hist_cnt[i])
			hist_cnt[i] = '0;
		parade_cnt.delete();
		scope_cnt.delete();
		space_max[0] = '0;
		space_max[1] = '0;
		hist_norm[0] = '0;
		hist_norm[1] = '0;
		parade_nrm = '0;
		scope_nrm = '0;
	endfunction

	function automatic void add_parade(int lane, logic [7:0] lvl, logic [7:0] k, int amount);
		int key;
		key = lane * 65536 + lvl * 256 + k;
		parade_cnt[key] = bump(parade_cnt.exists(key) ? parade_cnt[key] : 24'd0, amount);
	endfunction

	function automatic void finish_counts();
		longint unsigned area;
		logic [23:0] m;
		area = longint'(frame_w) * frame_h;
		for (int c = 0; c < 2; c++) begin
			m = '0;
			for (int i = 0; i < 768; i++)
				if (hist_cnt[c * 768 + i] > m)
					m = hist_cnt[c * 768 + i];
			space_max[c] = m;
			hist_norm[c] = (m != 0) ? HIST_SCALE / m : '0;
		end
		parade_nrm = (area != 0) ? 32'(64'h8000_0000 / area) : '0;
		scope_nrm = (area != 0) ? 32'(64'h4000_0000 / area) : '0;
	endfunction

	function automatic result_t read_bin(logic [3:0] sel, logic [15:0] idx);
		result_t r;
		longint unsigned v;
		int key;
		v = 0;
		r.status = 1'b0;
		if (sel <= SEL_HIST_LAST) begin
			if (idx < 256)
				v = (longint'(hist_cnt[sel * 256 + idx]) * hist_norm[sel / 3]) >> 24;
			else
				r.status = 1'b1;
		end else if (sel <= SEL_PARADE_LAST) begin
			key = (sel - SEL_PARADE_BASE) * 65536 + idx;
			if (parade_cnt.exists(key))
				v = (longint'(parade_cnt[key]) * parade_nrm) >> 8;
		end else if (sel == SEL_SCOPE) begin
			if (scope_cnt.exists(int'(idx)))
				v = (longint'(scope_cnt[int'(idx)]) * scope_nrm) >> 8;
		end else begin
			r.status = 1'b1;
		end
		r.bin_value = (v > COUNT_MAX) ? COUNT_MAX : v[23:0];
		return r;
	endfunction

	function automatic void apply_item(item_t it);
		logic [7:0] k;
		case (it.operation)
			OP_CLEAR: clear_counts();
			OP_PIXEL: begin
				k = bucket_of(it.column, 256);
				hist_cnt[0 * 256 + it.red] = bump(hist_cnt[0 * 256 + it.red], 1);
				hist_cnt[1 * 256 + it.green] = bump(hist_cnt[1 * 256 + it.green], 1);
				hist_cnt[2 * 256 + it.blue] = bump(hist_cnt[2 * 256 + it.blue], 1);
				hist_cnt[3 * 256 + it.luma] = bump(hist_cnt[3 * 256 + it.luma], 1);
				add_parade(0, it.luma, k, 1);
				add_parade(3, it.red, k, 1);
				add_parade(4, it.green, k, 1);
				add_parade(5, it.blue, k, 1);
				note_bin(SEL_HIST_R, {8'd0, it.red});
				note_bin(SEL_PARADE_BASE, {it.luma, k});
				note_bin(SEL_PARADE_G, {it.green, k});
			end
			OP_CHROMA: begin
				k = bucket_of(it.column, 512);
				hist_cnt[4 * 256 + it.cb_sample] = bump(hist_cnt[4 * 256 + it.cb_sample], 4);
				hist_cnt[5 * 256 + it.cr_sample] = bump(hist_cnt[5 * 256 + it.cr_sample], 4);
				add_parade(1, it.cb_sample, k, 4);
				add_parade(2, it.cr_sample, k, 4);
				scope_cnt[{it.cr_sample, it.cb_sample}] = bump(scope_cnt.exists(
					{it.cr_sample, it.cb_sample}) ? scope_cnt[{it.cr_sample, it.cb_sample}]
					: 24'd0, 1);
				note_bin(SEL_HIST_U, {8'd0, it.cb_sample});
				note_bin(SEL_PARADE_U, {it.cb_sample, k});
				note_bin(SEL_SCOPE, {it.cr_sample, it.cb_sample});
			end
			OP_FINISH: finish_counts();
			OP_READ: bins_due.push_back(read_bin(it.store_select, it.bin_index));
			default: ;
		endcase
	endfunction

	// accept side: predict each transaction and check each result
	always @(posedge clk) begin
		result_t want;
		if (item.valid && item.ready) begin
			apply_item(item.data);
			taken = 1'b1;
		end
		if (result.valid && result.ready) begin
			if (bins_due.size() == 0) begin
				$error("result with no read waiting: bin_value %0d status %0d",
					result.data.bin_value, result.data.status);
				error_count++;
			end else begin
				want = bins_due.pop_front();
				if (result.data.bin_value !== want.bin_value) begin
					$error("bin_value expected %0d actual %0d", want.bin_value,
						result.data.bin_value);
					error_count++;
				end
				if (result.data.status !== want.status) begin
					$error("status expected %0d actual %0d", want.status, result.data.status);
					error_count++;
				end
			end
		end
	end

	// item driver: bursts with random gaps
	always @(negedge clk) begin
		if (item.valid && !taken) begin
		end else if (gap_left > 0) begin
			gap_left--;
			item.valid <= 1'b0;
		end else if (pending.size() != 0) begin
			item.data <= pending.pop_front();
			item.valid <= 1'b1;
			burst_left--;
			if (burst_left <= 0) begin
				burst_left = $urandom_range(1, 24);
				gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
			end
		end else begin
			item.valid <= 1'b0;
		end
		taken = 1'b0;
	end

	// result stall pattern: free, random, mostly stalled
	always @(negedge clk) begin
		rx_cycle++;
		case ((rx_cycle / 300) % 3)
			0: result.ready <= 1'b1;
			1: result.ready <= 1'($urandom_range(0, 1));
			default: result.ready <= ($urandom_range(0, 3) == 0);
		endcase
	end

	function automatic item_t random_item(logic [2:0] op);
		item_t it;
		it = item_t'(ITEM_W'({$urandom, $urandom, $urandom}));
		it.operation = op;
		return it;
	endfunction

	task automatic send(item_t it);
		pending.push_back(it);
	endtask

	task automatic send_op(logic [2:0] op);
		send(random_item(op));
	endtask

	task automatic send_read(logic [3:0] sel, logic [15:0] idx);
		item_t it;
		it = random_item(OP_READ);
		it.store_select = sel;
		it.bin_index = idx;
		send(it);
	endtask

	task automatic send_pixel(logic [11:0] col, logic [7:0] y, logic [7:0] r, logic [7:0] g,
		logic [7:0] b);
		item_t it;
		it = random_item(OP_PIXEL);
		it.column = col;
		it.luma = y;
		it.red = r;
		it.green = g;
		it.blue = b;
		send(it);
	endtask

	task automatic send_chroma(logic [11:0] col, logic [7:0] u, logic [7:0] v);
		item_t it;
		it = random_item(OP_CHROMA);
		it.column = col;
		it.cb_sample = u;
		it.cr_sample = v;
		send(it);
	endtask

	// a read behind all earlier work returns only once the engine is idle
	task automatic drain();
		send_read(SEL_HIST_Y, 16'd0);
		while (pending.size() != 0 || item.valid || bins_due.size() != 0)
			@(posedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic [12:0] value);
		drain();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_write <= 1'b0;
		if (idx == CFG_WIDTH)
			frame_w = value;
		else
			frame_h = value[11:0];
	endtask

	task automatic test_directed_bins();
		send_read(SEL_PARADE_BASE, 16'd0);
		send_pixel(12'd0, 8'd0, 8'd255, 8'd255, 8'd255);
		send_pixel(12'd4095, 8'd255, 8'd0, 8'd0, 8'd0);
		send_pixel(12'd1919, 8'd128, 8'd255, 8'd1, 8'd127);
		send_chroma(12'd0, 8'd0, 8'd255);
		send_chroma(12'd4095, 8'd255, 8'd0);
		send_read(SEL_HIST_R, 16'd255);
		send_op(OP_FINISH);
		send_read(SEL_HIST_R, 16'd255);
		send_read(SEL_HIST_Y, 16'd0);
		send_read(SEL_HIST_U, 16'd0);
		send_read(SEL_PARADE_BASE, 16'hFFFF);
		send_read(SEL_PARADE_BASE, 16'd0);
		send_read(SEL_PARADE_U, 16'h00FF);
		send_read(SEL_SCOPE, 16'hFF00);
		send_read(SEL_SCOPE, 16'h00FF);
	endtask

	task automatic test_bad_reads_and_ops();
		send_read(SEL_HIST_R, 16'd256);
		send_read(SEL_HIST_LAST, 16'hFFFF);
		for (int s = SEL_SCOPE + 1; s < 16; s++)
			send_read(s[3:0], 16'd0);
		for (int op = OP_UNKNOWN_LO; op <= OP_UNKNOWN_HI; op++)
			send_op(op[2:0]);
		send_op(OP_CLEAR);
		send_op(OP_FINISH);
		send_read(SEL_HIST_Y, 16'd0);
		send_read(SEL_SCOPE, 16'd0);
		clears_left--;
	endtask

	task automatic random_frame(int n);
		int span;
		item_t it;
		bin_ref_t b;
		span = (frame_w > 1 && frame_w <= 4096) ? frame_w - 1 : 4095;
		if (clears_left > 0 && $urandom_range(0, 5) == 0) begin
			send_op(OP_CLEAR);
			clears_left--;
		end
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 19))
				0, 1, 2, 3, 4, 5, 6, 7: begin
					it = random_item(OP_PIXEL);
					if ($urandom_range(0, 3) != 0)
						it.column = 12'($urandom_range(0, span));
					send(it);
				end
				8, 9, 10, 11, 12: begin
					it = random_item(OP_CHROMA);
					if ($urandom_range(0, 3) != 0)
						it.column = 12'($urandom_range(0, span / 2));
					send(it);
				end
				13: send_op(3'($urandom_range(OP_UNKNOWN_LO, OP_UNKNOWN_HI)));
				14: send_read(4'($urandom_range(0, 15)), 16'($urandom));
				default: begin
					if (touched.size() != 0) begin
						b = touched[$urandom_range(0, touched.size() - 1)];
						send_read(b.sel, b.idx);
					end else begin
						send_read(4'($urandom_range(0, SEL_SCOPE)), 16'($urandom));
					end
				end
			endcase
		end
		send_op(OP_FINISH);
		for (int i = 0; i < 10 && touched.size() != 0; i++) begin
			b = touched[$urandom_range(0, touched.size() - 1)];
			send_read(b.sel, b.idx);
		end
	endtask

	task automatic test_random_frames();
		logic [12:0] widths [8];
		logic [12:0] heights [7];
		widths = '{13'd2, 13'd4096, 13'd8191, 13'd0, 13'd16, 13'd64, 13'd1920, 13'd640};
		heights = '{13'd2, 13'd2304, 13'h1FFF, 13'd0, 13'd4, 13'd1080, 13'd16};
		for (int f = 0; f < 30; f++) begin
			if (f % 2 == 0) begin
				if ($urandom_range(0, 2) == 0)
					write_reg(CFG_WIDTH, {12'($urandom_range(1, 2048)), 1'b0});
				else
					write_reg(CFG_WIDTH, widths[$urandom_range(0, 7)]);
			end else begin
				write_reg(CFG_HEIGHT, heights[$urandom_range(0, 6)]);
			end
			random_frame($urandom_range(20, 80));
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = 1'b0;
		cfg_data = '0;
		item.valid = 1'b0;
		item.data = '0;
		result.ready = 1'b0;
		error_count = 0;
		clears_left = 5;
		gap_left = 0;
		burst_left = 1;
		rx_cycle = 0;
		taken = 1'b0;
		frame_w = 13'd1920;
		frame_h = 12'd1080;
		clear_counts();
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		test_directed_bins();
		test_bad_reads_and_ops();
		write_reg(CFG_WIDTH, 13'd16);
		write_reg(CFG_HEIGHT, 13'd4);
		test_random_frames();

		while (pending.size() != 0 || item.valid || bins_due.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#40_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
design/vsse_pkg.sv
design/vsse_ifs.sv
design/video_scope_statistics_engine_core.sv
dv/video_scope_statistics_engine_core_test.sv
